// ===== sv/iir_fourth_order_filter_core_macros.svh =====
// Assertion macros shared by the filter RTL.
`ifndef IIR_FOURTH_ORDER_FILTER_CORE_MACROS_SVH
`define IIR_FOURTH_ORDER_FILTER_CORE_MACROS_SVH

`ifndef SYNTH
`define IIRF_ASSERT_SAME(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("iirf assertion failed");
`define IIRF_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("iirf assertion failed");
`else
`define IIRF_ASSERT_SAME(lbl, clk, rst_n, a, c)
`define IIRF_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif

`endif

// ===== sv/iirf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package iirf_pkg;

	localparam int FILTER_ORDER = 4;
	localparam int COEF_COUNT   = 7;
	localparam int COEF_W       = 16;
	localparam int HIST_W       = 32;
	localparam int OUT_W        = 18;
	localparam int FRAC_BITS    = 14;
	localparam int CFG_IDX_W    = 3;

	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [HIST_W-1:0] hist_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FF0 = 3'd0,
		REG_FF1 = 3'd1,
		REG_FF2 = 3'd2,
		REG_FB1 = 3'd3,
		REG_FB2 = 3'd4,
		REG_FB3 = 3'd5,
		REG_FB4 = 3'd6
	} coef_idx_t;

	localparam coef_t COEF_RESET [COEF_COUNT] = '{
		16'sd3845, 16'sd15381, 16'sd23072, 16'sd21407, 16'sd16883, 16'sd5937, 16'sd914
	};

endpackage

`default_nettype wire

// ===== sv/iir_fourth_order_filter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel    Direction  Handshake                   Payload
// sample     in         sample_valid/sample_stall   sample [SAMPLE_WIDTH]
// filtered   out        filtered_valid/filtered_stall  filtered [18] signed
// cfg        in         cfg_valid/cfg_ready         cfg_index [3], cfg_data [16]
//
// One sample per cycle when not stalled; registered in sample_s1, then filtered_q.
// The rate is set by the combinational feedback path: four 16x32 products on the
// output history, summed with the feedforward terms, truncated and saturated.
// Reset loads the default coefficients and clears both histories; no sweep.
// A stalled output still lets one more sample into the input register.
`include "iir_fourth_order_filter_core_macros.svh"

module iir_fourth_order_filter_core
	import iirf_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          sample_valid,
	output logic                         sample_stall,
	input  wire  [SAMPLE_WIDTH-1:0]      sample,
	output logic                         filtered_valid,
	input  wire                          filtered_stall,
	output logic signed [OUT_W-1:0]      filtered,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [CFG_IDX_W-1:0]         cfg_index,
	input  wire  [COEF_W-1:0]            cfg_data
);

	localparam int PairW  = SAMPLE_WIDTH + 2;
	localparam int FfpW   = PairW + COEF_W;
	localparam int FfW    = SAMPLE_WIDTH + 20;
	localparam int FbpW   = HIST_W + COEF_W;
	localparam int FbW    = FbpW + 2;
	localparam int AccW   = ((FfW + FRAC_BITS > FbW) ? FfW + FRAC_BITS : FbW) + 1;
	localparam int YqW    = AccW - FRAC_BITS;
	localparam logic [FRAC_BITS-1:0] FracMask = {FRAC_BITS{1'b1}};

	coef_t                   coef_q    [COEF_COUNT];
	logic [SAMPLE_WIDTH-1:0] x_hist_q  [FILTER_ORDER];
	hist_t                   y_hist_q  [FILTER_ORDER];

	logic                    valid_s1;
	logic [SAMPLE_WIDTH-1:0] sample_s1;
	logic                    out_valid_q;
	logic signed [OUT_W-1:0] filtered_q;

	logic advance;
	logic moving;
	logic load;

	logic signed [PairW-1:0] pair04, pair13, mid2;
	logic signed [FfpW-1:0]  ffp0, ffp1, ffp2;
	logic signed [FfW-1:0]   ff;
	logic signed [FbpW-1:0]  fbp [FILTER_ORDER];
	logic signed [FbW-1:0]   fb;
	logic signed [AccW-1:0]  acc, acc_adj;
	logic signed [YqW-1:0]   yq_wide;
	hist_t                   yq;
	hist_t                   y_adj;
	logic signed [OUT_W-1:0] y_int;
	hist_t                   h0_adj;
	logic signed [OUT_W-1:0] h0_int;

	assign cfg_ready      = 1'b1;
	assign advance        = !out_valid_q || !filtered_stall;
	assign moving         = valid_s1 && advance;
	assign sample_stall   = valid_s1 && !advance;
	assign load           = sample_valid && !sample_stall;
	assign filtered_valid = out_valid_q;
	assign filtered       = filtered_q;

	always_comb begin
		pair04 = $signed({2'b00, sample_s1}) + $signed({2'b00, x_hist_q[3]});
		pair13 = $signed({2'b00, x_hist_q[0]}) + $signed({2'b00, x_hist_q[2]});
		mid2   = $signed({2'b00, x_hist_q[1]});
		ffp0   = FfpW'(coef_q[REG_FF0]) * FfpW'(pair04);
		ffp1   = FfpW'(coef_q[REG_FF1]) * FfpW'(pair13);
		ffp2   = FfpW'(coef_q[REG_FF2]) * FfpW'(mid2);
		ff     = FfW'(ffp0) + FfW'(ffp1) + FfW'(ffp2);

		fbp[0] = FbpW'(coef_q[REG_FB1]) * FbpW'(y_hist_q[0]);
		fbp[1] = FbpW'(coef_q[REG_FB2]) * FbpW'(y_hist_q[1]);
		fbp[2] = FbpW'(coef_q[REG_FB3]) * FbpW'(y_hist_q[2]);
		fbp[3] = FbpW'(coef_q[REG_FB4]) * FbpW'(y_hist_q[3]);
		fb     = FbW'(fbp[0]) + FbW'(fbp[1]) + FbW'(fbp[2]) + FbW'(fbp[3]);

		acc     = (AccW'(ff) <<< FRAC_BITS) - AccW'(fb);
		// truncate toward zero: bias negatives before the shift
		acc_adj = acc + (acc[AccW-1] ? AccW'(FracMask) : AccW'(0));
		yq_wide = acc_adj[AccW-1:FRAC_BITS];
		if (yq_wide[YqW-1:HIST_W-1] == '0 || yq_wide[YqW-1:HIST_W-1] == '1) begin
			yq = yq_wide[HIST_W-1:0];
		end else if (yq_wide[YqW-1]) begin
			yq = {1'b1, {(HIST_W-1){1'b0}}};
		end else begin
			yq = {1'b0, {(HIST_W-1){1'b1}}};
		end

		y_adj  = yq + (yq[HIST_W-1] ? HIST_W'(FracMask) : HIST_W'(0));
		y_int  = y_adj[HIST_W-1:FRAC_BITS];
		h0_adj = y_hist_q[0] + (y_hist_q[0][HIST_W-1] ? HIST_W'(FracMask) : HIST_W'(0));
		h0_int = h0_adj[HIST_W-1:FRAC_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COEF_COUNT; i++) begin
				coef_q[i] <= COEF_RESET[i];
			end
		end else if (cfg_valid && cfg_ready && (int'(cfg_index) < COEF_COUNT)) begin
			coef_q[cfg_index] <= coef_t'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FILTER_ORDER; i++) begin
				x_hist_q[i] <= '0;
				y_hist_q[i] <= '0;
			end
		end else if (moving) begin
			x_hist_q[0] <= sample_s1;
			y_hist_q[0] <= yq;
			for (int i = 1; i < FILTER_ORDER; i++) begin
				x_hist_q[i] <= x_hist_q[i-1];
				y_hist_q[i] <= y_hist_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (moving) begin
				out_valid_q <= 1'b1;
			end else if (!filtered_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sample_s1 <= sample;
		end
		if (moving) begin
			filtered_q <= y_int;
		end
	end

	`IIRF_ASSERT_SAME(a_stall_needs_full, clk, arst_n, sample_stall, valid_s1)
	`IIRF_ASSERT_NEXT(a_move_gives_out, clk, arst_n, moving, out_valid_q)
	`IIRF_ASSERT_NEXT(a_blocked_holds, clk, arst_n, valid_s1 && !advance, valid_s1)
	`IIRF_ASSERT_NEXT(a_out_matches_hist, clk, arst_n, moving, filtered_q == h0_int)

endmodule

`default_nettype wire

// ===== test/iir_filter_checker.sv =====
`timescale 1ns / 1ps

module iir_filter_checker
	import iirf_pkg::*;
(
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     sample_valid,
	input  wire                     sample_stall,
	input  wire  [15:0]             sample,
	input  wire                     filtered_valid,
	input  wire                     filtered_stall,
	input  wire  signed [OUT_W-1:0] filtered,
	input  wire                     cfg_valid,
	input  wire                     cfg_ready,
	input  wire  [CFG_IDX_W-1:0]    cfg_index,
	input  wire  [COEF_W-1:0]       cfg_data,
	output int                      mismatches,
	output int                      outstanding
);

	localparam longint FRAC_ONE = longint'(1) << FRAC_BITS;
	localparam longint HIST_MAX = (longint'(1) << (HIST_W - 1)) - 1;
	localparam longint HIST_MIN = -(longint'(1) << (HIST_W - 1));
	localparam longint OUT_MAX  = (longint'(1) << (OUT_W - 1)) - 1;
	localparam longint OUT_MIN  = -(longint'(1) << (OUT_W - 1));

	coef_t                   taps [COEF_COUNT];
	logic [15:0]             x_hist [FILTER_ORDER];
	hist_t                   y_hist [FILTER_ORDER];
	logic signed [OUT_W-1:0] filtered_due [$];
	logic signed [OUT_W-1:0] want;
	int                      errs;

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// one filter step: returns the output and shifts both histories
	function automatic logic signed [OUT_W-1:0] filter_step(input logic [15:0] x_new);
		longint ff;
		longint fb;
		longint yq;
		longint yi;
		ff = longint'(taps[REG_FF0]) * (longint'(x_new) + longint'(x_hist[3]))
			+ longint'(taps[REG_FF1]) * (longint'(x_hist[0]) + longint'(x_hist[2]))
			+ longint'(taps[REG_FF2]) * longint'(x_hist[1]);
		fb = 0;
		for (int i = 0; i < FILTER_ORDER; i++)
			fb += longint'(taps[int'(REG_FB1) + i]) * longint'(y_hist[i]);
		yq = clamp((ff * FRAC_ONE - fb) / FRAC_ONE, HIST_MIN, HIST_MAX);
		yi = clamp(yq / FRAC_ONE, OUT_MIN, OUT_MAX);
		for (int i = FILTER_ORDER - 1; i > 0; i--) begin
			x_hist[i] = x_hist[i - 1];
			y_hist[i] = y_hist[i - 1];
		end
		x_hist[0] = x_new;
		y_hist[0] = hist_t'(yq);
		return yi[OUT_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps = COEF_RESET;
			for (int i = 0; i < FILTER_ORDER; i++) begin
				x_hist[i] = '0;
				y_hist[i] = '0;
			end
			filtered_due.delete();
			errs = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready && cfg_index < COEF_COUNT)
				taps[cfg_index] = cfg_data;
			if (sample_valid && !sample_stall)
				filtered_due.push_back(filter_step(sample));
			if (filtered_valid && !filtered_stall) begin
				if (filtered_due.size() == 0) begin
					errs++;
					$display("%0t: filtered beat with nothing expected, actual %0d",
						$time, filtered);
				end else begin
					want = filtered_due.pop_front();
					if (filtered !== want) begin
						errs++;
						$display("%0t: filtered mismatch, expected %0d actual %0d",
							$time, want, filtered);
					end
				end
			end
			mismatches <= errs;
			outstanding <= filtered_due.size();
		end
	end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import iirf_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam coef_t COEF_MAX = 16'sh7FFF;
	localparam coef_t COEF_MIN = 16'sh8000;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 88;
	localparam int HOLD_CYCLES = 40;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     sample_valid = 1'b0;
	logic                     sample_stall;
	logic [15:0]              sample = '0;
	logic                     filtered_valid;
	logic                     filtered_stall = 1'b0;
	logic signed [OUT_W-1:0]  filtered;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [COEF_W-1:0]        cfg_data = '0;
	int                       mismatches;
	int                       outstanding;
	bit                       quiet = 1'b0;
	bit                       hold_req = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	iir_fourth_order_filter_core #(
		.SAMPLE_WIDTH(16)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.sample         (sample),
		.filtered_valid (filtered_valid),
		.filtered_stall (filtered_stall),
		.filtered       (filtered),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	iir_filter_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.sample         (sample),
		.filtered_valid (filtered_valid),
		.filtered_stall (filtered_stall),
		.filtered       (filtered),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatches     (mismatches),
		.outstanding    (outstanding)
	);

	task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input coef_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_coefs(input coef_t c [COEF_COUNT]);
		for (int i = 0; i < COEF_COUNT; i++)
			write_coef(CFG_IDX_W'(i), c[i]);
	endtask

	task automatic fill_coefs(input coef_t v);
		coef_t c [COEF_COUNT];
		foreach (c[i])
			c[i] = v;
		load_coefs(c);
	endtask

	// valid stays high across back-to-back beats
	task automatic send_sample(input logic [15:0] v);
		sample_valid <= 1'b1;
		sample <= v;
		do @(posedge clk); while (sample_stall);
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// output side back-pressure
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				filtered_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				filtered_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				filtered_stall <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	initial begin
		static logic [15:0] opening [11] = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'h0000, 16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'h5555, 16'hAAAA};
		static logic [15:0] blast [5] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000};
		coef_t set [COEF_COUNT];
		logic [15:0] v;
		int pos;

		pos = 32768;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset coefficients
		foreach (opening[i])
			send_sample(opening[i]);
		drain();

		// history saturates high and low
		fill_coefs(COEF_MAX);
		for (int i = 0; i < 4; i++)
			send_sample(blast[i]);
		drain();
		fill_coefs(COEF_MIN);
		write_coef(REG_UNUSED, COEF_MAX);
		foreach (blast[i])
			send_sample(blast[i]);
		drain();
		fill_coefs('0);
		send_sample(16'hFFFF);
		send_sample(16'h3039);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p % 3)
				0: set = COEF_RESET;
				1: foreach (set[i]) set[i] = coef_t'($urandom());
				default: begin
					foreach (set[i]) begin
						case ($urandom_range(0, 3))
							0: set[i] = COEF_MAX;
							1: set[i] = COEF_MIN;
							2: set[i] = '0;
							default: set[i] = COEF_RESET[i]
								+ coef_t'($urandom_range(0, 2000)) - coef_t'(1000);
						endcase
					end
				end
			endcase
			load_coefs(set);
			if (p == 2)
				hold_req = 1'b1;
			if (p == PHASES - 1)
				quiet = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (!quiet && !(p == 2 && n < 50) && $urandom_range(0, 4) == 0) begin
					sample_valid <= 1'b0;
					repeat ($urandom_range(1, 11)) @(posedge clk);
				end
				case ($urandom_range(0, 9))
					0: v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
					1, 2, 3: v = 16'($urandom());
					default: begin
						// smooth position track
						pos += int'($urandom_range(0, 2048)) - 1024;
						if (pos < 0)
							pos = 0;
						if (pos > 65535)
							pos = 65535;
						v = pos[15:0];
					end
				endcase
				send_sample(v);
			end
			drain();
		end

		repeat (10) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("iir_fourth_order_filter_core test passed");
		else
			$display("iir_fourth_order_filter_core test failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("iir_fourth_order_filter_core test failed");
		$finish;
	end

endmodule
